// ===== hw/rtl/mcb_pkg.sv =====
// Shared types and codes for the maze carver block.
package mcb_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int EV_W    = 3;
    localparam int COORD_W = 6;
    localparam int WALL_W  = 4;
    localparam int DEPTH_W = 13;

    // Configuration register indexes (paddr[2])
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // All four walls standing
    localparam logic [WALL_W-1:0] WALLS_ALL = 4'hF;

    typedef enum logic [FUNC_W-1:0] {
        FN_STEP    = 2'd0,
        FN_QUERY   = 2'd1,
        FN_RESTART = 2'd2
    } func_t;

    typedef enum logic [EV_W-1:0] {
        EV_CARVED      = 3'd0,
        EV_BACKTRACKED = 3'd1,
        EV_FINISHED    = 3'd2,
        EV_WALL_READ   = 3'd3,
        EV_RESTARTED   = 3'd4
    } ev_t;

endpackage

// ===== hw/rtl/maze_carver_backtracker_top.sv =====
// Maze carver: randomized depth-first search over a grid held in a cell memory.
//
// Channel  | Direction | Signals                        | Payload
// ---------+-----------+--------------------------------+------------------------------------
// s_       | in        | s_tvalid s_tready s_tdata s_tuser | command transaction
// m_       | out       | m_tvalid m_tready m_tdata m_tuser | result transaction
// apb      | in/out    | psel penable pwrite paddr pwdata prdata pready | grid_cols, grid_rows
//
// The restart sweep covers all 2**(CW+RW) cell addresses (4096 at 64 x 64).
// The single read port of the cell memory sets the step time: the current cell and its
// four neighbours are read one per cycle before the choice is made.
// Reset (rst_n low, asynchronous) and restart both start the sweep that writes every cell
// back to unvisited with all walls; s_tready stays low during it, APB writes still land.
// A finished result sits in the output register while the next command is taken; the
// sequencer waits in its emit state only if that register is still full.
module maze_carver_backtracker_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [mcb_pkg::DATA_W-1:0]  pwdata,
    output logic [mcb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Command stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // random_value[15:0], query_col[21:16], query_row[27:22], zero[31:28]
    input  logic [mcb_pkg::DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [mcb_pkg::FUNC_W-1:0]  s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // cur_col[5:0], cur_row[11:6], wall_bits[15:12], stack_depth[28:16], done_res[29],
    // zero[31:30]
    output logic [mcb_pkg::DATA_W-1:0]  m_tdata,
    // event_res[2:0]
    output logic [mcb_pkg::EV_W-1:0]    m_tuser
);

    // Cell and stack geometry. Cells are addressed as {row, col}.
    localparam int CW        = $clog2(MAX_COLS);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int AW        = CW + RW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int SAW       = $clog2(CELLS);
    localparam int SPW       = $clog2(CELLS + 1);
    localparam int UCW       = $clog2(MAX_COLS + 1);
    localparam int URW       = $clog2(MAX_ROWS + 1);
    localparam int CCW       = (UCW > mcb_pkg::CFG_W) ? UCW : mcb_pkg::CFG_W;
    localparam int CRW       = (URW > mcb_pkg::CFG_W) ? URW : mcb_pkg::CFG_W;
    localparam int ENTRY_W   = mcb_pkg::WALL_W + 1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_READ     = 9'b000000010,
        S_DECIDE   = 9'b000000100,
        S_WR_THERE = 9'b000001000,
        S_POP      = 9'b000010000,
        S_POP_CELL = 9'b000100000,
        S_QUERY    = 9'b001000000,
        S_EMIT     = 9'b010000000,
        S_CLEAR    = 9'b100000000
    } state_t;

    // random_value mod 3, one base-4 digit per term
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] m;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        case (t)
            3'd0, 3'd3, 3'd6: m = 2'd0;
            3'd1, 3'd4, 3'd7: m = 2'd1;
            default:          m = 2'd2;
        endcase
        return m;
    endfunction

    // ---------------------------------------------------------------- configuration
    logic [mcb_pkg::CFG_W-1:0] grid_cols_reg;
    logic [mcb_pkg::CFG_W-1:0] grid_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= 7'd50;
            grid_rows_reg <= 7'd50;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                mcb_pkg::CFG_COLS: grid_cols_reg <= pwdata[mcb_pkg::CFG_W-1:0];
                mcb_pkg::CFG_ROWS: grid_rows_reg <= pwdata[mcb_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mcb_pkg::CFG_ROWS) ? mcb_pkg::DATA_W'(grid_rows_reg)
                                                    : mcb_pkg::DATA_W'(grid_cols_reg);

    // Saturate the grid size to [2, MAX]
    logic [CCW-1:0] gc_ext;
    logic [CRW-1:0] gr_ext;
    logic [UCW-1:0] used_cols;
    logic [URW-1:0] used_rows;

    always_comb
    begin
        gc_ext = CCW'(grid_cols_reg);
        gr_ext = CRW'(grid_rows_reg);
        if (gc_ext < CCW'(2))
            used_cols = UCW'(2);
        else if (gc_ext > CCW'(MAX_COLS))
            used_cols = UCW'(MAX_COLS);
        else
            used_cols = UCW'(gc_ext);
        if (gr_ext < CRW'(2))
            used_rows = URW'(2);
        else if (gr_ext > CRW'(MAX_ROWS))
            used_rows = URW'(MAX_ROWS);
        else
            used_rows = URW'(gr_ext);
    end

    // ---------------------------------------------------------------- registers
    state_t                       state_reg, state_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic                         emit_after_reg, emit_after_next;
    logic [CW-1:0]                cur_col_reg, cur_col_next;
    logic [RW-1:0]                cur_row_reg, cur_row_next;
    logic [SPW-1:0]               sp_reg, sp_next;
    logic                         finished_reg, finished_next;
    logic                         m_valid_reg, m_valid_next;

    logic [mcb_pkg::WALL_W-1:0]   here_walls_reg, here_walls_next;
    logic [3:0]                   nbr_vis_reg, nbr_vis_next;
    logic [mcb_pkg::WALL_W-1:0]   nbr_walls_reg [4];
    logic [mcb_pkg::WALL_W-1:0]   nbr_walls_next [4];
    logic [1:0]                   dir_reg, dir_next;
    logic [1:0]                   rnd_lo_reg, rnd_lo_next;
    logic [1:0]                   rnd_m3_reg, rnd_m3_next;
    logic                         q_oob_reg, q_oob_next;
    mcb_pkg::ev_t                 pend_ev_reg, pend_ev_next;
    logic [mcb_pkg::WALL_W-1:0]   pend_walls_reg, pend_walls_next;

    mcb_pkg::ev_t                 m_ev_reg, m_ev_next;
    logic [mcb_pkg::COORD_W-1:0]  m_col_reg, m_col_next;
    logic [mcb_pkg::COORD_W-1:0]  m_row_reg, m_row_next;
    logic [mcb_pkg::WALL_W-1:0]   m_walls_reg, m_walls_next;
    logic [mcb_pkg::DEPTH_W-1:0]  m_depth_reg, m_depth_next;
    logic                         m_done_reg, m_done_next;

    // ---------------------------------------------------------------- memories
    // Cell memory entry: {visited, walls}
    logic [ENTRY_W-1:0] cell_mem [MEM_DEPTH];
    logic               cm_re, cm_we;
    logic [AW-1:0]      cm_raddr, cm_waddr;
    logic [ENTRY_W-1:0] cm_wdata;
    logic [ENTRY_W-1:0] cm_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cell_mem[cm_waddr] <= cm_wdata;
        if (cm_re)
            cm_rdata_reg <= cell_mem[cm_raddr];
    end

    // Backtrack stack entry: {row, col}
    logic [AW-1:0]  stk_mem [CELLS];
    logic           stk_re, stk_we;
    logic [SAW-1:0] stk_raddr, stk_waddr;
    logic [AW-1:0]  stk_wdata;
    logic [AW-1:0]  stk_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rdata_reg <= stk_mem[stk_raddr];
    end

    // ---------------------------------------------------------------- neighbourhood
    // Neighbours in order top, right, bottom, left; wrapped addresses are masked by nbr_in.
    logic [CW-1:0] nbr_col [4];
    logic [RW-1:0] nbr_row [4];
    logic [AW-1:0] here_addr;
    logic          here_in_grid;
    logic [3:0]    nbr_in;
    logic [3:0]    avail;
    logic [2:0]    avail_cnt;
    logic [1:0]    pick;
    logic [2:0]    seen;
    logic [1:0]    dir_sel;
    logic [3:0]    dir_mask, opp_mask;

    always_comb
    begin
        here_addr  = {cur_row_reg, cur_col_reg};
        nbr_col[0] = cur_col_reg;
        nbr_row[0] = cur_row_reg - RW'(1);
        nbr_col[1] = cur_col_reg + CW'(1);
        nbr_row[1] = cur_row_reg;
        nbr_col[2] = cur_col_reg;
        nbr_row[2] = cur_row_reg + RW'(1);
        nbr_col[3] = cur_col_reg - CW'(1);
        nbr_row[3] = cur_row_reg;

        here_in_grid = (UCW'(cur_col_reg) < used_cols) && (URW'(cur_row_reg) < used_rows);
        nbr_in[0]    = here_in_grid && (cur_row_reg != '0);
        nbr_in[1]    = here_in_grid && ((UCW'(cur_col_reg) + UCW'(1)) < used_cols);
        nbr_in[2]    = here_in_grid && ((URW'(cur_row_reg) + URW'(1)) < used_rows);
        nbr_in[3]    = here_in_grid && (cur_col_reg != '0);

        avail     = nbr_in & ~nbr_vis_reg;
        avail_cnt = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);

        case (avail_cnt)
            3'd2:    pick = {1'b0, rnd_lo_reg[0]};
            3'd3:    pick = rnd_m3_reg;
            3'd4:    pick = rnd_lo_reg;
            default: pick = 2'd0;
        endcase

        // Take the pick-th open neighbour
        seen    = '0;
        dir_sel = '0;
        for (int d = 0; d < 4; d++)
        begin
            if (avail[d])
            begin
                if (seen == 3'(pick))
                    dir_sel = 2'(d);
                seen = seen + 3'd1;
            end
        end

        dir_mask = 4'b0001 << dir_sel;
        opp_mask = 4'b0001 << (dir_reg + 2'd2);
    end

    // ---------------------------------------------------------------- sequencer
    logic [15:0]                 in_rnd;
    logic [mcb_pkg::COORD_W-1:0] in_qcol, in_qrow;
    logic                        out_free;
    logic [SPW-1:0]              sp_dec;

    assign in_rnd   = s_tdata[15:0];
    assign in_qcol  = s_tdata[21:16];
    assign in_qrow  = s_tdata[27:22];
    assign out_free = !m_valid_reg || m_tready;
    assign sp_dec   = sp_reg - SPW'(1);
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        clr_addr_next   = clr_addr_reg;
        emit_after_next = emit_after_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        sp_next         = sp_reg;
        finished_next   = finished_reg;
        here_walls_next = here_walls_reg;
        nbr_vis_next    = nbr_vis_reg;
        nbr_walls_next  = nbr_walls_reg;
        dir_next        = dir_reg;
        rnd_lo_next     = rnd_lo_reg;
        rnd_m3_next     = rnd_m3_reg;
        q_oob_next      = q_oob_reg;
        pend_ev_next    = pend_ev_reg;
        pend_walls_next = pend_walls_reg;

        m_valid_next    = m_valid_reg && !m_tready;
        m_ev_next       = m_ev_reg;
        m_col_next      = m_col_reg;
        m_row_next      = m_row_reg;
        m_walls_next    = m_walls_reg;
        m_depth_next    = m_depth_reg;
        m_done_next     = m_done_reg;

        cm_re     = 1'b0;
        cm_raddr  = here_addr;
        cm_we     = 1'b0;
        cm_waddr  = here_addr;
        cm_wdata  = {1'b1, here_walls_reg};
        stk_re    = 1'b0;
        stk_raddr = sp_dec[SAW-1:0];
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = here_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        mcb_pkg::FN_STEP:
                        begin
                            // Fetch the current cell first
                            cm_re       = 1'b1;
                            cm_raddr    = here_addr;
                            cnt_next    = '0;
                            rnd_lo_next = in_rnd[1:0];
                            rnd_m3_next = mod3_16(in_rnd);
                            state_next  = S_READ;
                        end
                        mcb_pkg::FN_QUERY:
                        begin
                            cm_re      = 1'b1;
                            cm_raddr   = {RW'(in_qrow), CW'(in_qcol)};
                            q_oob_next = (32'(in_qcol) >= MAX_COLS) || (32'(in_qrow) >= MAX_ROWS);
                            state_next = S_QUERY;
                        end
                        mcb_pkg::FN_RESTART:
                        begin
                            cur_col_next    = '0;
                            cur_row_next    = '0;
                            sp_next         = '0;
                            finished_next   = 1'b0;
                            clr_addr_next   = '0;
                            emit_after_next = 1'b1;
                            pend_ev_next    = mcb_pkg::EV_RESTARTED;
                            pend_walls_next = mcb_pkg::WALLS_ALL;
                            state_next      = S_CLEAR;
                        end
                        default: ;  // unused command: drop, no result
                    endcase
                end
            end

            S_READ:
            begin
                if (cnt_reg == 3'd0)
                    here_walls_next = cm_rdata_reg[mcb_pkg::WALL_W-1:0];
                else
                begin
                    nbr_vis_next[2'(cnt_reg - 3'd1)]   = cm_rdata_reg[mcb_pkg::WALL_W];
                    nbr_walls_next[2'(cnt_reg - 3'd1)] = cm_rdata_reg[mcb_pkg::WALL_W-1:0];
                end

                if ((cnt_reg == 3'd0) && finished_reg)
                begin
                    // Walk already done: report the current cell unchanged
                    pend_ev_next    = mcb_pkg::EV_FINISHED;
                    pend_walls_next = cm_rdata_reg[mcb_pkg::WALL_W-1:0];
                    state_next      = S_EMIT;
                end
                else if (cnt_reg == 3'd4)
                    state_next = S_DECIDE;
                else
                begin
                    cm_re    = 1'b1;
                    cm_raddr = {nbr_row[cnt_reg[1:0]], nbr_col[cnt_reg[1:0]]};
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            S_DECIDE:
            begin
                cm_we    = 1'b1;
                cm_waddr = here_addr;
                if (avail_cnt != 3'd0)
                begin
                    // Mark here visited, open the wall, push and move
                    cm_wdata = {1'b1, here_walls_reg & ~dir_mask};
                    if (sp_reg < SPW'(CELLS))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + SPW'(1);
                    end
                    cur_col_next = nbr_col[dir_sel];
                    cur_row_next = nbr_row[dir_sel];
                    dir_next     = dir_sel;
                    state_next   = S_WR_THERE;
                end
                else
                begin
                    cm_wdata = {1'b1, here_walls_reg};
                    if (sp_reg != '0)
                    begin
                        stk_re     = 1'b1;
                        sp_next    = sp_dec;
                        state_next = S_POP;
                    end
                    else
                    begin
                        finished_next   = 1'b1;
                        pend_ev_next    = mcb_pkg::EV_FINISHED;
                        pend_walls_next = here_walls_reg;
                        state_next      = S_EMIT;
                    end
                end
            end

            S_WR_THERE:
            begin
                // Current cell is now the chosen neighbour
                cm_we           = 1'b1;
                cm_waddr        = here_addr;
                cm_wdata        = {nbr_vis_reg[dir_reg], nbr_walls_reg[dir_reg] & ~opp_mask};
                pend_walls_next = nbr_walls_reg[dir_reg] & ~opp_mask;
                if (sp_reg == '0)
                begin
                    finished_next = 1'b1;
                    pend_ev_next  = mcb_pkg::EV_FINISHED;
                end
                else
                    pend_ev_next = mcb_pkg::EV_CARVED;
                state_next = S_EMIT;
            end

            S_POP:
            begin
                cur_row_next = stk_rdata_reg[AW-1:CW];
                cur_col_next = stk_rdata_reg[CW-1:0];
                cm_re        = 1'b1;
                cm_raddr     = stk_rdata_reg;
                if (sp_reg == '0)
                begin
                    finished_next = 1'b1;
                    pend_ev_next  = mcb_pkg::EV_FINISHED;
                end
                else
                    pend_ev_next = mcb_pkg::EV_BACKTRACKED;
                state_next = S_POP_CELL;
            end

            S_POP_CELL:
            begin
                pend_walls_next = cm_rdata_reg[mcb_pkg::WALL_W-1:0];
                state_next      = S_EMIT;
            end

            S_QUERY:
            begin
                pend_ev_next    = mcb_pkg::EV_WALL_READ;
                pend_walls_next = q_oob_reg ? mcb_pkg::WALLS_ALL
                                            : cm_rdata_reg[mcb_pkg::WALL_W-1:0];
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_ev_next    = pend_ev_reg;
                    m_col_next   = mcb_pkg::COORD_W'(cur_col_reg);
                    m_row_next   = mcb_pkg::COORD_W'(cur_row_reg);
                    m_walls_next = pend_walls_reg;
                    m_depth_next = mcb_pkg::DEPTH_W'(sp_reg);
                    m_done_next  = finished_reg;
                    state_next   = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                // Sweep: every cell unvisited with all walls
                cm_we         = 1'b1;
                cm_waddr      = clr_addr_reg;
                cm_wdata      = {1'b0, mcb_pkg::WALLS_ALL};
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    emit_after_next = 1'b0;
                    state_next      = emit_after_reg ? S_EMIT : S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            clr_addr_reg   <= '0;
            emit_after_reg <= 1'b0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            sp_reg         <= '0;
            finished_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clr_addr_reg   <= clr_addr_next;
            emit_after_reg <= emit_after_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            sp_reg         <= sp_next;
            finished_reg   <= finished_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        here_walls_reg <= here_walls_next;
        nbr_vis_reg    <= nbr_vis_next;
        nbr_walls_reg  <= nbr_walls_next;
        dir_reg        <= dir_next;
        rnd_lo_reg     <= rnd_lo_next;
        rnd_m3_reg     <= rnd_m3_next;
        q_oob_reg      <= q_oob_next;
        pend_ev_reg    <= pend_ev_next;
        pend_walls_reg <= pend_walls_next;
        m_ev_reg       <= m_ev_next;
        m_col_reg      <= m_col_next;
        m_row_reg      <= m_row_next;
        m_walls_reg    <= m_walls_next;
        m_depth_reg    <= m_depth_next;
        m_done_reg     <= m_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ev_reg;
    assign m_tdata  = {2'b00, m_done_reg, m_depth_reg, m_walls_reg, m_row_reg, m_col_reg};

endmodule

// ===== hw/rtl/mcb_checker.sv =====
// Port-level checks for the maze carver, bound to its top level.
module mcb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [mcb_pkg::FUNC_W-1:0] s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mcb_pkg::DATA_W-1:0] m_tdata,
    input logic [mcb_pkg::EV_W-1:0]   m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A restart transaction starts the sweep: no command is taken next cycle
    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == mcb_pkg::FN_RESTART) |=> !s_tready)
        else $error("command taken right after restart");

    // Restart reports origin, all walls, empty stack, not done
    a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mcb_pkg::EV_RESTARTED) |-> (m_tdata[29:0] == 30'h0000_F000))
        else $error("restart result not cleared");

    // Finished means done with an empty stack; moves never report done
    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == mcb_pkg::EV_FINISHED) ? (m_tdata[29] && m_tdata[28:16] == 13'd0)
                      : ((m_tuser == mcb_pkg::EV_CARVED || m_tuser == mcb_pkg::EV_BACKTRACKED)
                         ? !m_tdata[29] : 1'b1)))
        else $error("done flag inconsistent with event");

endmodule

bind maze_carver_backtracker_top mcb_checker u_mcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
